@@ src/integer_to_ascii_radix_core_defines.svh @@
// Assertion macros for the integer to ASCII radix converter RTL, used by itoa_back.
// Plain text only; no dependencies.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITOA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/itoa_pkg.sv @@
// Shared types, constants and the digit-to-character function.
// No dependencies.
`default_nettype none

package itoa_pkg;

    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 8;
    localparam int DIV_STEPS = 8;   // long-division bits per cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 8'h41;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 4'd10;

    typedef struct packed {
        logic neg;          // emit '-' before the digits
        logic single_zero;  // emit a lone '0' (zero value or unusable radix)
    } job_flags_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DEC_DIGITS)
        begin
            res = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end
        else
        begin
            res = CHAR_ALPHA + {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_DIGITS};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/itoa_front.sv @@
// Input side: accepts items and classifies them (sign, magnitude, lone zero).
// Depends on itoa_pkg.
`default_nettype none

module itoa_front import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int IN_W        = 40
) (
    input  wire logic [RADIX_W-1:0]     radix,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_W-1:0]        s_tdata,   // value, is_signed
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic [VALUE_WIDTH-1:0]      q_mag,
    output job_flags_t                  q_flags
);

    logic [VALUE_WIDTH-1:0] val;
    logic                   sgn;
    logic                   bad_radix;
    logic                   is_zero;
    logic                   neg;

    assign val       = s_tdata[VALUE_WIDTH-1:0];
    assign sgn       = s_tdata[VALUE_WIDTH];
    assign bad_radix = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    assign is_zero   = (val == '0);
    assign neg       = sgn && val[VALUE_WIDTH-1];

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    // Most negative value negates to itself, read unsigned that is 2^(W-1).
    assign q_mag               = neg ? (~val + 1'b1) : val;
    assign q_flags.single_zero = bad_radix || is_zero;
    assign q_flags.neg         = neg && !(bad_radix || is_zero);

endmodule

`default_nettype wire

@@ src/itoa_queue.sv @@
// Two-entry job queue between the front and the back.
// Depends on itoa_pkg only through its users.
`default_nettype none

module itoa_queue #(
    parameter int WIDTH = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/itoa_back.sv @@
// Output side: digit extraction by multi-bit long division, digit stack,
// reversed emission through a registered output. Depends on itoa_pkg and
// integer_to_ascii_radix_core_defines.svh.
`default_nettype none
`include "integer_to_ascii_radix_core_defines.svh"

module itoa_back import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [RADIX_W-1:0] radix,
    input  wire logic               q_empty,
    output logic                    q_pop,
    input  wire logic [VALUE_WIDTH-1:0] q_mag,
    input  wire job_flags_t         q_flags,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [CHAR_W-1:0]       m_tdata,   // character
    output logic                    m_tlast
);

    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ZERO = 6'b000010,
        S_SIGN = 6'b000100,
        S_DIV  = 6'b001000,
        S_RD   = 6'b010000,
        S_OUT  = 6'b100000
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [AW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]      m_tdata_reg;
    logic                   m_tlast_reg;

    logic [DIGIT_W-1:0]     digit_mem [VALUE_WIDTH];
    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    logic [DIGIT_W-1:0]     step_rem;
    logic [VALUE_WIDTH-1:0] step_quot;
    logic                   div_last;
    logic                   slot_free;
    logic                   out_load;
    logic [CHAR_W-1:0]      out_char;
    logic                   out_last;

    // Up to DIV_STEPS restoring-division bits per cycle; remainder stays below radix.
    always_comb
    begin
        logic [DIGIT_W-1:0]     r;
        logic [VALUE_WIDTH-1:0] d;
        logic [RADIX_W-1:0]     t;
        r = rem_reg;
        d = dvd_reg;
        t = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (int'(bit_cnt_reg) + i < VALUE_WIDTH)
            begin
                t = {r, d[VALUE_WIDTH-1]};
                if (t >= radix)
                begin
                    t = t - radix;
                    d = {d[VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    d = {d[VALUE_WIDTH-2:0], 1'b0};
                end
                r = t[DIGIT_W-1:0];
            end
        end
        step_rem  = r;
        step_quot = d;
    end

    assign div_last  = (int'(bit_cnt_reg) + DIV_STEPS >= VALUE_WIDTH);
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg;
        out_load     = 1'b0;
        out_char     = CHAR_ZERO;
        out_last     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    dvd_next     = q_mag;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    cnt_next     = '0;
                    if (q_flags.single_zero)
                        state_next = S_ZERO;
                    else if (q_flags.neg)
                        state_next = S_SIGN;
                    else
                        state_next = S_DIV;
                end
            end
            S_ZERO:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_char   = CHAR_ZERO;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_char   = CHAR_MINUS;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                dvd_next = step_quot;
                if (div_last)
                begin
                    mem_we       = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (step_quot == '0)
                        state_next = S_RD;
                end
                else
                begin
                    rem_next     = step_rem;
                    bit_cnt_next = bit_cnt_reg + AW'(DIV_STEPS);
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(cnt_reg - 1'b1);
                ptr_next   = AW'(cnt_reg - 1'b1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    out_char = digit_char(rd_data_reg);
                    out_last = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg - 1'b1;
                        ptr_next  = ptr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bit_cnt_reg  <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (out_load)
        begin
            m_tdata_reg <= out_char;
            m_tlast_reg <= out_last;
        end
    end

    // Digit stack, least significant digit at the bottom.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[cnt_reg[AW-1:0]] <= step_rem;
        end
        if (mem_re)
        begin
            rd_data_reg <= digit_mem[mem_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `ITOA_ASSERT_IMPL(a_rem_below_radix, clk, rst_n, state_reg == S_DIV, {1'b0, rem_reg} < radix, "remainder not below radix")
    `ITOA_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !m_tvalid_reg || m_tready, "output item overwritten while pending")
    `ITOA_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, !q_empty, "pop from empty queue")
    `ITOA_ASSERT_NEXT(a_div_to_read, clk, rst_n, (state_reg == S_DIV) && div_last && (step_quot == '0), (state_reg == S_RD) && (cnt_reg != '0), "division end not followed by stack read")

endmodule

`default_nettype wire

@@ src/integer_to_ascii_radix_core.sv @@
// Top level of the integer to ASCII radix converter: radix register,
// front, queue and back. Depends on itoa_pkg, itoa_front, itoa_queue, itoa_back.
//
// Usage:
//   s_tvalid/s_tready/s_tdata : one item per integer; s_tdata holds value in the
//     low VALUE_WIDTH bits and is_signed just above, zero padded to whole bytes.
//   m_tvalid/m_tready/m_tdata/m_tlast : one item per character, most significant
//     digit first, '-' leading for a negative signed value; m_tlast marks the
//     final character of each number. A zero value or a radix outside 2..16
//     gives a single '0'.
//   cfg_valid/cfg_ready/cfg_data : writes the radix (reset 10); cfg_ready is
//     always high. Write it only while no conversion is in flight.
// Operation: the back pops a job, emits a leading '-' for a negative value,
//   extracts each digit in turn in the long-division unit (8 bits per cycle),
//   reads the top of the digit stack, then emits one character per cycle while
//   the receiver is ready. One job is converted at a time.
// The two-entry queue lets the input side take up to two further items while
//   one is converted. A stalled receiver holds the output register and stalls
//   the back only when it must emit; the front keeps filling the queue.
// Reset clears the queue, the control state and the output valid, and sets the
//   radix to 10. No clearing pass is needed.
`default_nettype none

module integer_to_ascii_radix_core import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [((VALUE_WIDTH+8)/8)*8-1:0] s_tdata,  // value, is_signed
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [CHAR_W-1:0]           m_tdata,   // character
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [RADIX_W-1:0]     cfg_data   // radix
);

    localparam int IN_W = ((VALUE_WIDTH + 8) / 8) * 8;
    localparam int JOB_W = VALUE_WIDTH + $bits(job_flags_t);

    logic [RADIX_W-1:0]     radix_reg, radix_next;

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_empty;
    logic [VALUE_WIDTH-1:0] push_mag;
    job_flags_t             push_flags;
    logic [JOB_W-1:0]       pop_data;
    logic [VALUE_WIDTH-1:0] pop_mag;
    job_flags_t             pop_flags;

    // Radix register: always ready.
    assign cfg_ready  = 1'b1;
    assign radix_next = cfg_valid ? cfg_data : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IN_W        (IN_W)
    ) u_front (
        .radix    (radix_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_mag    (push_mag),
        .q_flags  (push_flags)
    );

    itoa_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_flags, push_mag}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign pop_mag   = pop_data[VALUE_WIDTH-1:0];
    assign pop_flags = job_flags_t'(pop_data[JOB_W-1:VALUE_WIDTH]);

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .radix    (radix_reg),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_mag    (pop_mag),
        .q_flags  (pop_flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
